// File: hdl/vehicle_drive_enable_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Drive enable sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_DRIVE_ENABLE_SEQUENCER_DEFINES_SVH
`define VEHICLE_DRIVE_ENABLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define VDES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vdes assertion failed");

// Next-cycle implication.
`define VDES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vdes assertion failed");

`endif

// File: hdl/vdes_pkg.sv
// ----------------------------------------------------------------------------
// Drive enable sequencer package
// Mode codes, register indexes, reset values and stream widths.
// ----------------------------------------------------------------------------
package vdes_pkg;

  typedef enum logic [2:0] {
    ModeStart     = 3'd0,
    ModePrecharge = 3'd1,
    ModePrechOk   = 3'd2,
    ModeRtdDelay  = 3'd3,
    ModeDrive     = 3'd4,
    ModePrechErr  = 3'd5,
    ModeFault     = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    RegPrechargeRatio = 3'd0,
    RegInvCutoff      = 3'd1,
    RegGlvCutoff      = 3'd2,
    RegBrakeThresh    = 3'd3,
    RegRtdDelay       = 3'd4,
    RegTorqueLimit    = 3'd5,
    RegAppsDeadzone   = 3'd6,
    RegHornPeriod     = 3'd7
  } reg_idx_e;

  localparam int unsigned InWidth   = 112;
  localparam int unsigned OutWidth  = 40;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned IdxWidth  = 3;

  localparam logic [7:0]  HornTickReset      = 8'd10;
  localparam logic [7:0]  HornCountMax       = 8'd255;
  localparam logic [7:0]  PrechargeRatioRst  = 8'd230;
  localparam logic [15:0] InvCutoffRst       = 16'd600;
  localparam logic [15:0] GlvCutoffRst       = 16'd105;
  localparam logic [11:0] BrakeThreshRst     = 12'd200;
  localparam logic [15:0] RtdDelayRst        = 16'd2000;
  localparam logic [15:0] TorqueLimitRst     = 16'd1000;
  localparam logic [12:0] AppsDeadzoneRst    = 13'd205;
  localparam logic [7:0]  HornPeriodRst      = 8'd10;

endpackage

// File: hdl/vehicle_drive_enable_sequencer.sv
// ----------------------------------------------------------------------------
// Vehicle drive enable sequencer
// Steps start, precharge, precharge ok, ready-to-drive delay, drive, precharge error and fault.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave stream transfer is one control tick with the sensor readings
//   and a millisecond timestamp. The sequencer runs the handler of the
//   current mode on that tick and emits one master stream transfer holding
//   the new mode and the output register values after the tick.
//   Configuration registers are written on cfg_we_i with cfg_idx_i selecting
//   the register; write them only while no tick is in flight.
// Throughput:
//   One result per tick, in the cycle after its transfer. A tick is taken
//   every cycle unless a result stalls; one pass of compares and two narrow
//   multiplies (precharge ratio and torque scaling) feed the result register.
// Stall:
//   The result register holds its transfer while m_axis_tready is low; a new
//   tick is still taken in the cycle the pending result is taken.
// Reset:
//   rst_ni clears the mode to start, all output registers to zero, the horn
//   counter to ten and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module vehicle_drive_enable_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [vdes_pkg::IdxWidth-1:0] cfg_idx_i,
  input  logic [vdes_pkg::CfgWidth-1:0] cfg_data_i,
  // Tick stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: dc_bus_voltage[15:0], pack_voltage[31:16], glv_voltage[47:32],
  //        rtd_button[48], brake_pressure[60:49], pedal_position[73:61],
  //        time_ms[105:74], zero fill [111:106]
  input  logic [vdes_pkg::InWidth-1:0]  s_axis_tdata,
  // Result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: mode[2:0], precharge_enable_out[3], precharge_ok_out[4],
  //        inverter_enable_out[5], torque_limit_out[21:6],
  //        torque_request[37:22], horn[38], zero fill [39]
  output logic [vdes_pkg::OutWidth-1:0] m_axis_tdata
);
  import vdes_pkg::*;

  // Configuration registers
  logic [7:0]  prech_ratio_q;
  logic [15:0] inv_cutoff_q;
  logic [15:0] glv_cutoff_q;
  logic [11:0] brake_thresh_q;
  logic [15:0] rtd_delay_q;
  logic [15:0] torque_limit_q;
  logic [12:0] apps_deadzone_q;
  logic [7:0]  horn_period_q;

  // Sequencer state
  mode_e       mode_q, mode_d;
  logic [31:0] phase_start_q, phase_start_d;
  logic [7:0]  horn_cnt_q, horn_cnt_d;
  logic        horn_phase_q, horn_phase_d;
  logic        horn_level_q, horn_level_d;
  logic [1:0]  prech_flags_q, prech_flags_d;
  logic        inv_en_q, inv_en_d;
  logic [15:0] tq_limit_q, tq_limit_d;
  logic [15:0] tq_req_q, tq_req_d;

  // Result register
  logic                out_valid_q;
  logic [OutWidth-1:0] out_data_q, out_data_d;

  // Tick fields
  logic [15:0] dc, pack, glv;
  logic        button;
  logic [11:0] brake;
  logic [12:0] pedal;
  logic [31:0] now;

  assign dc     = s_axis_tdata[15:0];
  assign pack   = s_axis_tdata[31:16];
  assign glv    = s_axis_tdata[47:32];
  assign button = s_axis_tdata[48];
  assign brake  = s_axis_tdata[60:49];
  assign pedal  = s_axis_tdata[73:61];
  assign now    = s_axis_tdata[105:74];

  logic        in_xfer;
  logic        armed, glv_low, ratio_ok, dc_ok, delay_done;
  logic [23:0] dc_scaled, pack_scaled;
  logic [31:0] elapsed;
  logic [12:0] throttle;
  logic [28:0] tq_product;
  logic [16:0] tq_scaled;
  logic [15:0] tq_sat;
  logic [7:0]  horn_inc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign armed       = button && (brake > brake_thresh_q);
  assign glv_low     = glv <= glv_cutoff_q;
  // Exact ratio check: dc * 256 against pack * ratio
  assign dc_scaled   = {dc, 8'd0};
  assign pack_scaled = 24'(pack) * 24'(prech_ratio_q);
  assign ratio_ok    = dc_scaled >= pack_scaled;
  assign dc_ok       = dc >= inv_cutoff_q;
  assign elapsed     = now - phase_start_q;
  assign delay_done  = elapsed >= {16'd0, rtd_delay_q};

  // Torque request: deadzone, scale by limit, drop twelve fraction bits
  assign throttle   = (pedal > apps_deadzone_q) ? pedal : 13'd0;
  assign tq_product = 29'(throttle) * 29'(torque_limit_q);
  assign tq_scaled  = tq_product[28:12];
  assign tq_sat     = tq_scaled[16] ? 16'hFFFF : tq_scaled[15:0];

  // Horn counter saturates before the period compare
  assign horn_inc = (horn_cnt_q < HornCountMax) ? horn_cnt_q + 8'd1 : horn_cnt_q;

  always_comb begin
    mode_d        = mode_q;
    phase_start_d = phase_start_q;
    horn_cnt_d    = horn_cnt_q;
    horn_phase_d  = horn_phase_q;
    horn_level_d  = horn_level_q;
    prech_flags_d = prech_flags_q;
    inv_en_d      = inv_en_q;
    tq_limit_d    = tq_limit_q;
    tq_req_d      = tq_req_q;
    unique case (mode_q)
      ModeStart: begin
        prech_flags_d = 2'b00;
        inv_en_d      = 1'b0;
        tq_limit_d    = 16'd0;
        tq_req_d      = 16'd0;
        phase_start_d = now;
        mode_d        = ModePrecharge;
      end
      ModePrecharge: begin
        prech_flags_d = 2'b01;
        tq_req_d      = 16'd0;
        if (ratio_ok && dc_ok) begin
          mode_d = ModePrechOk;
        end
      end
      ModePrechOk: begin
        // Cutoff is not checked here; glv lockout wins over everything
        prech_flags_d = 2'b11;
        horn_level_d  = 1'b0;
        if (armed) begin
          mode_d        = ModeRtdDelay;
          phase_start_d = now;
        end
        if (!ratio_ok) begin
          mode_d = ModePrechErr;
        end
        if (glv_low) begin
          mode_d = ModeFault;
        end
      end
      ModeRtdDelay: begin
        tq_req_d   = 16'd0;
        horn_cnt_d = horn_inc;
        if (horn_inc >= horn_period_q) begin
          horn_cnt_d   = 8'd0;
          horn_phase_d = !horn_phase_q;
          horn_level_d = !horn_phase_q;
        end
        if (!armed) begin
          mode_d = ModePrechOk;
        end else if (delay_done) begin
          mode_d        = ModeDrive;
          phase_start_d = now;
        end
      end
      ModeDrive: begin
        // Low bus drops back to start with the request held
        inv_en_d     = 1'b1;
        tq_limit_d   = torque_limit_q;
        horn_level_d = 1'b0;
        mode_d       = ModeStart;
        if (dc_ok) begin
          tq_req_d = tq_sat;
          mode_d   = ModeDrive;
        end
        if (glv_low) begin
          mode_d = ModeFault;
        end
      end
      ModePrechErr: begin
        prech_flags_d = 2'b00;
        tq_req_d      = 16'd0;
      end
      default: begin
        // Fault, and the unused code, settle in fault
        prech_flags_d = 2'b00;
        tq_req_d      = 16'd0;
        mode_d        = ModeFault;
      end
    endcase
  end

  assign out_data_d = {1'b0, horn_level_d, tq_req_d, tq_limit_d, inv_en_d,
                       prech_flags_d[1], prech_flags_d[0], mode_d};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prech_ratio_q   <= PrechargeRatioRst;
      inv_cutoff_q    <= InvCutoffRst;
      glv_cutoff_q    <= GlvCutoffRst;
      brake_thresh_q  <= BrakeThreshRst;
      rtd_delay_q     <= RtdDelayRst;
      torque_limit_q  <= TorqueLimitRst;
      apps_deadzone_q <= AppsDeadzoneRst;
      horn_period_q   <= HornPeriodRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPrechargeRatio: prech_ratio_q   <= cfg_data_i[7:0];
        RegInvCutoff:      inv_cutoff_q    <= cfg_data_i;
        RegGlvCutoff:      glv_cutoff_q    <= cfg_data_i;
        RegBrakeThresh:    brake_thresh_q  <= cfg_data_i[11:0];
        RegRtdDelay:       rtd_delay_q     <= cfg_data_i;
        RegTorqueLimit:    torque_limit_q  <= cfg_data_i;
        RegAppsDeadzone:   apps_deadzone_q <= cfg_data_i[12:0];
        RegHornPeriod:     horn_period_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state: advance on each tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeStart;
      phase_start_q <= 32'd0;
      horn_cnt_q    <= HornTickReset;
      horn_phase_q  <= 1'b0;
      horn_level_q  <= 1'b0;
      prech_flags_q <= 2'b00;
      inv_en_q      <= 1'b0;
      tq_limit_q    <= 16'd0;
      tq_req_q      <= 16'd0;
    end else if (in_xfer) begin
      mode_q        <= mode_d;
      phase_start_q <= phase_start_d;
      horn_cnt_q    <= horn_cnt_d;
      horn_phase_q  <= horn_phase_d;
      horn_level_q  <= horn_level_d;
      prech_flags_q <= prech_flags_d;
      inv_en_q      <= inv_en_d;
      tq_limit_q    <= tq_limit_d;
      tq_req_q      <= tq_req_d;
    end
  end

  // Result register: load on tick transfer, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hdl/vdes_checker.sv
// ----------------------------------------------------------------------------
// Drive enable sequencer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "vehicle_drive_enable_sequencer_defines.svh"

module vdes_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vdes_pkg::OutWidth-1:0] m_axis_tdata
);
  import vdes_pkg::*;

  logic [2:0] out_mode;
  logic       inv_en_mode_ok;
  logic       horn_mode_ok;
  assign out_mode = m_axis_tdata[2:0];

  // Only the drive handler raises the enable; start clears it, fault holds it
  assign inv_en_mode_ok = (out_mode == ModeDrive) || (out_mode == ModeStart) ||
                          (out_mode == ModeFault);
  // Only the delay handler raises the horn; it leaves to precharge ok or drive
  assign horn_mode_ok = (out_mode == ModeRtdDelay) || (out_mode == ModePrechOk) ||
                        (out_mode == ModeDrive);

  // A stalled result holds
  `VDES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Every tick transfer gives a result in the next cycle
  `VDES_ASSERT_NEXT(a_tick_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
  // Precharge ok is only shown with precharge enable
  `VDES_ASSERT_NOW(a_ok_needs_en, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[3])
  // Inverter enable is shown only in drive or in the modes drive leaves to
  `VDES_ASSERT_NOW(a_inv_en_mode, m_axis_tvalid && m_axis_tdata[5], inv_en_mode_ok)
  // Horn sounds only on a result of the ready-to-drive delay
  `VDES_ASSERT_NOW(a_horn_in_delay, m_axis_tvalid && m_axis_tdata[38], horn_mode_ok)

endmodule

bind vehicle_drive_enable_sequencer vdes_checker u_vdes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/vehicle_drive_enable_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive enable sequencer stream test
// Drives control ticks through the sequencer and compares every status
// transfer against a cycle-free model of the mode machine. A short directed
// walk through start, precharge, delay and drive comes first, then phases of
// shaped random ticks under varied register settings, with random gaps on
// both streams. The run ends in random noise that lands in a terminal mode.
// ----------------------------------------------------------------------------
module vehicle_drive_enable_sequencer_test;
  import vdes_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  // One control tick as it travels on the slave stream
  typedef struct {
    logic [15:0] dc;
    logic [15:0] pack;
    logic [15:0] glv;
    logic        button;
    logic [11:0] brake;
    logic [12:0] pedal;
    logic [31:0] time_ms;
  } tick_t;

  // One status word as it travels on the master stream
  typedef struct {
    mode_e       mode;
    logic        pc_en;
    logic        pc_ok;
    logic        inv_en;
    logic [15:0] tq_lim;
    logic [15:0] tq_req;
    logic        horn;
  } status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the mode machine per accepted tick and holds the
  // status words still owed by the block.
  // --------------------------------------------------------------------------
  class sequencer_scoreboard;
    logic [7:0]  ratio_cfg;
    logic [15:0] inv_cutoff;
    logic [15:0] glv_cutoff;
    logic [11:0] brake_thr;
    logic [15:0] rtd_delay;
    logic [15:0] torque_cfg;
    logic [12:0] deadzone;
    logic [7:0]  horn_period;

    mode_e       mode;
    logic [31:0] phase_t0;
    logic [7:0]  horn_cnt;
    logic        horn_phase;
    logic        horn_lvl;
    logic [1:0]  pc_flags;
    logic        inv_en;
    logic [15:0] tq_lim;
    logic [15:0] tq_req;

    status_t     status_fifo[$];
    int          fails;

    function new();
      ratio_cfg   = PrechargeRatioRst;
      inv_cutoff  = InvCutoffRst;
      glv_cutoff  = GlvCutoffRst;
      brake_thr   = BrakeThreshRst;
      rtd_delay   = RtdDelayRst;
      torque_cfg  = TorqueLimitRst;
      deadzone    = AppsDeadzoneRst;
      horn_period = HornPeriodRst;
      mode        = ModeStart;
      phase_t0    = '0;
      horn_cnt    = HornTickReset;
      horn_phase  = 1'b0;
      horn_lvl    = 1'b0;
      pc_flags    = '0;
      inv_en      = 1'b0;
      tq_lim      = '0;
      tq_req      = '0;
      fails       = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [15:0] val);
      case (idx)
        RegPrechargeRatio: ratio_cfg   = val[7:0];
        RegInvCutoff:      inv_cutoff  = val;
        RegGlvCutoff:      glv_cutoff  = val;
        RegBrakeThresh:    brake_thr   = val[11:0];
        RegRtdDelay:       rtd_delay   = val;
        RegTorqueLimit:    torque_cfg  = val;
        RegAppsDeadzone:   deadzone    = val[12:0];
        RegHornPeriod:     horn_period = val[7:0];
        default: ;
      endcase
    endfunction

    // Exact Q0.8 compare: dc * 256 >= pack * ratio
    function bit ratio_met(logic [15:0] dc, logic [15:0] pack);
      return {8'd0, dc, 8'd0} >= 32'(pack) * 32'(ratio_cfg);
    endfunction

    // Run the handler of the current mode on one tick and queue the status
    function void note_tick(tick_t t);
      logic        armed;
      logic        glv_low;
      logic [31:0] elapsed;
      logic [31:0] prod;
      logic [12:0] throttle;
      mode_e       nxt;
      status_t     s;
      armed   = t.button && (t.brake > brake_thr);
      glv_low = t.glv <= glv_cutoff;
      case (mode)
        ModeStart: begin
          pc_flags = '0;
          inv_en   = 1'b0;
          tq_lim   = '0;
          tq_req   = '0;
          phase_t0 = t.time_ms;
          nxt      = ModePrecharge;
        end
        ModePrecharge: begin
          pc_flags = 2'b01;
          tq_req   = '0;
          nxt = (ratio_met(t.dc, t.pack) && t.dc >= inv_cutoff) ? ModePrechOk : ModePrecharge;
        end
        ModePrechOk: begin
          // Ratio only here, the cutoff is not rechecked; low supply wins last
          pc_flags = 2'b11;
          horn_lvl = 1'b0;
          nxt      = ModePrechOk;
          if (armed) begin
            nxt      = ModeRtdDelay;
            phase_t0 = t.time_ms;
          end
          if (!ratio_met(t.dc, t.pack)) nxt = ModePrechErr;
          if (glv_low) nxt = ModeFault;
        end
        ModeRtdDelay: begin
          elapsed = t.time_ms - phase_t0;
          tq_req  = '0;
          if (horn_cnt < HornCountMax) horn_cnt = horn_cnt + 8'd1;
          if (horn_cnt >= horn_period) begin
            horn_cnt   = '0;
            horn_phase = ~horn_phase;
            horn_lvl   = horn_phase;
          end
          if (!armed) begin
            nxt = ModePrechOk;
          end else if (elapsed < {16'd0, rtd_delay}) begin
            nxt = ModeRtdDelay;
          end else begin
            nxt      = ModeDrive;
            phase_t0 = t.time_ms;
          end
        end
        ModeDrive: begin
          throttle = (t.pedal > deadzone) ? t.pedal : '0;
          inv_en   = 1'b1;
          tq_lim   = torque_cfg;
          horn_lvl = 1'b0;
          nxt      = ModeStart;
          // Request holds its old value when the bus drops below cutoff
          if (t.dc >= inv_cutoff) begin
            prod   = (32'(throttle) * 32'(torque_cfg)) >> 12;
            tq_req = (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
            nxt    = ModeDrive;
          end
          if (glv_low) nxt = ModeFault;
        end
        ModePrechErr: begin
          pc_flags = '0;
          tq_req   = '0;
          nxt      = ModePrechErr;
        end
        default: begin
          // Fault, and the unused code, settle in fault
          pc_flags = '0;
          tq_req   = '0;
          nxt      = ModeFault;
        end
      endcase
      mode     = nxt;
      s.mode   = mode;
      s.pc_en  = pc_flags[0];
      s.pc_ok  = pc_flags[1];
      s.inv_en = inv_en;
      s.tq_lim = tq_lim;
      s.tq_req = tq_req;
      s.horn   = horn_lvl;
      status_fifo.push_back(s);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_status(logic [OutWidth-1:0] d);
      status_t want;
      if (status_fifo.size() == 0) begin
        $error("status transfer with nothing expected: %h", d);
        fails++;
        return;
      end
      want = status_fifo.pop_front();
      compare_field("mode", 32'(want.mode), 32'(d[2:0]));
      compare_field("precharge_enable_out", 32'(want.pc_en), 32'(d[3]));
      compare_field("precharge_ok_out", 32'(want.pc_ok), 32'(d[4]));
      compare_field("inverter_enable_out", 32'(want.inv_en), 32'(d[5]));
      compare_field("torque_limit_out", 32'(want.tq_lim), 32'(d[21:6]));
      compare_field("torque_request", 32'(want.tq_req), 32'(d[37:22]));
      compare_field("horn", 32'(want.horn), 32'(d[38]));
    endfunction

    function int pending();
      return status_fifo.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutWidth-1:0] m_axis_tdata;

  vehicle_drive_enable_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sequencer_scoreboard sb;
  bit                  send_burst;
  bit                  recv_burst;
  logic [31:0]         clock_ms;
  int                  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tick_t make_tick(logic [15:0] dc, logic [15:0] pack, logic [15:0] glv,
                                      logic btn, logic [11:0] brake, logic [12:0] pedal,
                                      logic [31:0] ms);
    tick_t t;
    t.dc      = dc;
    t.pack    = pack;
    t.glv     = glv;
    t.button  = btn;
    t.brake   = brake;
    t.pedal   = pedal;
    t.time_ms = ms;
    return t;
  endfunction

  // Build the next tick for the mode the model is in. Shaped ticks keep the
  // sequence out of the terminal modes; noise goes anywhere.
  function automatic tick_t build_tick(bit noise_only);
    tick_t       t;
    logic [31:0] need;
    logic [31:0] floor_dc;
    bit          shaped;
    bit          armed;
    t.dc     = 16'($urandom);
    t.pack   = 16'($urandom);
    t.glv    = 16'($urandom);
    t.button = 1'($urandom);
    t.brake  = 12'($urandom);
    t.pedal  = 13'($urandom_range(0, 4096));
    // Advance the millisecond clock; jump now and then to cover wraparound
    if ($urandom_range(0, 63) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 32'(sb.rtd_delay) / 4 + 20);
    t.time_ms = clock_ms;

    shaped = !noise_only;
    // Modes that cannot fall into a terminal mode take raw noise at times
    if ((sb.mode == ModeStart || sb.mode == ModePrecharge || sb.mode == ModeRtdDelay) &&
        $urandom_range(0, 4) == 0) shaped = 1'b0;
    if (!shaped) return t;

    // Keep the low-voltage supply above its lockout
    if (sb.glv_cutoff != 16'hFFFF) begin
      if ($urandom_range(0, 7) == 0) t.glv = sb.glv_cutoff + 16'd1;
      else t.glv = 16'($urandom_range(32'(sb.glv_cutoff) + 1, 65535));
    end

    case ($urandom_range(0, 7))
      0: t.pedal = sb.deadzone;
      1: t.pedal = (sb.deadzone < 13'd4096) ? sb.deadzone + 13'd1 : 13'd4096;
      2: t.pedal = 13'd4096;
      default: ;
    endcase

    // Smallest dc that meets the ratio, and the one that also meets cutoff
    need     = (32'(t.pack) * 32'(sb.ratio_cfg) + 32'd255) >> 8;
    floor_dc = (need > 32'(sb.inv_cutoff)) ? need : 32'(sb.inv_cutoff);
    case (sb.mode)
      ModePrecharge: begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 3) == 0) t.dc = 16'(floor_dc);
          else t.dc = 16'($urandom_range(floor_dc, 65535));
        end
      end
      ModePrechOk: begin
        if ($urandom_range(0, 3) == 0) t.dc = 16'(need);
        else t.dc = 16'($urandom_range(need, 65535));
      end
      ModeDrive: begin
        // Mostly hold the bus up; sometimes drop it to fall back to start
        if ($urandom_range(0, 19) < 17) t.dc = 16'($urandom_range(sb.inv_cutoff, 65535));
        else if (sb.inv_cutoff != 16'd0) t.dc = 16'($urandom_range(0, sb.inv_cutoff - 1));
      end
      default: ;
    endcase

    case (sb.mode)
      ModePrechOk:  armed = $urandom_range(0, 9) < 4;
      ModeRtdDelay: armed = $urandom_range(0, 24) != 0;
      default:      armed = 1'($urandom);
    endcase
    if (armed && sb.brake_thr != 12'hFFF) begin
      t.button = 1'b1;
      t.brake  = 12'($urandom_range(32'(sb.brake_thr) + 1, 4095));
    end else if (!armed && t.button) begin
      t.brake = 12'($urandom_range(0, sb.brake_thr));
    end
    return t;
  endfunction

  // Offer one tick after a random gap and hold it until the transfer
  task automatic send_tick(input tick_t t);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t.time_ms, t.pedal, t.brake, t.button, t.glv, t.pack, t.dc};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(t);
  endtask

  // Drop valid and hold off until every owed status word has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write all registers while the block is idle, then run a batch of ticks
  task automatic run_phase(input logic [15:0] cfg [8], input int n_ticks, input bit noise_only);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= cfg[i];
      @(posedge clk_i);
      sb.set_register(reg_idx_e'(i), cfg[i]);
    end
    cfg_we_i <= 1'b0;
    for (int n = 0; n < n_ticks; n++) begin
      send_tick(build_tick(noise_only));
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] cfg [8];
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_burst    = 1'b0;
    clock_ms      = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk under reset settings
    send_tick(make_tick(16'd0, 16'd0, 16'd0, 1'b0, 12'd0, 13'd0, 32'd0));
    // Precharge: bus one below cutoff, then ratio short by a hair, then met
    send_tick(make_tick(16'd599, 16'd0, 16'd0, 1'b0, 12'd0, 13'd0, 32'd5));
    send_tick(make_tick(16'd600, 16'd668, 16'd0, 1'b0, 12'd0, 13'd0, 32'd10));
    send_tick(make_tick(16'd600, 16'd667, 16'd0, 1'b0, 12'd0, 13'd0, 32'd15));
    // Precharge ok ignores the cutoff; brake at threshold does not arm
    send_tick(make_tick(16'd100, 16'd0, 16'd106, 1'b1, 12'd200, 13'd0, 32'd20));
    send_tick(make_tick(16'd100, 16'd0, 16'd106, 1'b0, 12'd4095, 13'd0, 32'd25));
    send_tick(make_tick(16'd100, 16'd0, 16'd106, 1'b1, 12'd201, 13'd0, 32'd1000));
    // Delay: horn toggles, leave for drive exactly at the hold time
    for (int k = 1; k <= 7; k++)
      send_tick(make_tick(16'd0, 16'd0, 16'd0, 1'b1, 12'd4095, 13'd0, 32'(1000 + k)));
    send_tick(make_tick(16'd0, 16'd0, 16'd0, 1'b1, 12'd4095, 13'd0, 32'd2999));
    send_tick(make_tick(16'd0, 16'd0, 16'd0, 1'b1, 12'd4095, 13'd0, 32'd3000));
    // Drive: full pedal, pedal at and just past the deadzone, bus drop
    send_tick(make_tick(16'd600, 16'd0, 16'd106, 1'b0, 12'd0, 13'd4096, 32'd3001));
    send_tick(make_tick(16'd600, 16'd0, 16'd106, 1'b0, 12'd0, 13'd205, 32'd3002));
    send_tick(make_tick(16'd600, 16'd0, 16'd106, 1'b0, 12'd0, 13'd206, 32'd3003));
    send_tick(make_tick(16'd599, 16'd0, 16'd106, 1'b0, 12'd0, 13'd4096, 32'd3004));
    // Second pass with all fields at their top, delay across the clock wrap
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 13'd4096, 32'hFFFF_FFFF));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 13'd4096, 32'd0));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 13'd0, 32'hFFFF_F800));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 13'd0, 32'h0000_0200));
    send_tick(make_tick(16'hFFFF, 16'd0, 16'd106, 1'b0, 12'd0, 13'd4096, 32'h0000_0201));

    // Low extremes; a horn period of zero toggles every delay tick
    cfg = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    run_phase(cfg, 300, 1'b0);
    // High extremes, keeping the lockout and brake threshold just reachable
    cfg = '{16'd255, 16'hFFFF, 16'hFFFE, 16'd4094, 16'hFFFF, 16'hFFFF, 16'd4096, 16'd255};
    run_phase(cfg, 300, 1'b0);
    // Mid-range random settings
    repeat (4) begin
      cfg[RegPrechargeRatio] = 16'($urandom_range(0, 255));
      cfg[RegInvCutoff]      = 16'($urandom);
      cfg[RegGlvCutoff]      = 16'($urandom_range(0, 65534));
      cfg[RegBrakeThresh]    = 16'($urandom_range(0, 4094));
      cfg[RegRtdDelay]       = 16'($urandom_range(0, 3000));
      cfg[RegTorqueLimit]    = 16'($urandom);
      cfg[RegAppsDeadzone]   = 16'($urandom_range(0, 4096));
      cfg[RegHornPeriod]     = 16'($urandom_range(1, 12));
      run_phase(cfg, 300, 1'b0);
    end
    // Closing noise: expected to end in precharge error or fault for good
    cfg[RegGlvCutoff]   = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
    cfg[RegBrakeThresh] = 16'd4095;
    cfg[RegHornPeriod]  = 16'($urandom_range(1, 255));
    run_phase(cfg, 80, 1'b1);

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Status receiver: stall a random number of cycles before each transfer
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    recv_burst    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Check every status transfer against the oldest owed word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
  end

  // Watchdog: end the run when neither stream moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
